/* hdl/utf8_byte_stream_decoder_unit_assert.svh */
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Shared concurrent assertion forms for the decoder modules.
// ----------------------------------------------------------------------------
`ifndef UTF8_BYTE_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_BYTE_STREAM_DECODER_UNIT_ASSERT_SVH

// Check a property on every clock edge outside of reset.
`define U8D_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define U8D_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hdl/u8d_pkg.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder package
// Byte classes, field widths and the lead byte classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

    localparam int BYTE_W      = 8;
    localparam int CP_W        = 21;
    localparam int LEN_W       = 3;
    localparam int PEND_W      = 2;
    localparam int QUEUE_DEPTH = 2;

    // Lead byte masks and patterns
    localparam logic [7:0] ASCII_MASK = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_PAT  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_PAT  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_PAT  = 8'hF0;
    localparam logic [7:0] CONT_MASK  = 8'h3F;

    typedef enum logic [2:0] {
        KIND_ASCII,
        KIND_LEAD2,
        KIND_LEAD3,
        KIND_LEAD4,
        KIND_CONT,
        KIND_INVALID
    } u8d_kind_t;

    // One classified byte traveling from front to back
    typedef struct packed {
        u8d_kind_t         kind;
        logic [BYTE_W-1:0] data;
    } u8d_item_t;

    // Classify a byte as if it were a lead byte
    function automatic u8d_kind_t u8d_classify(input logic [BYTE_W-1:0] b);
        u8d_kind_t k;
        if ((b & ASCII_MASK) == 8'h00) begin
            k = KIND_ASCII;
        end
        else if ((b & LEAD2_MASK) == LEAD2_PAT) begin
            k = KIND_LEAD2;
        end
        else if ((b & LEAD3_MASK) == LEAD3_PAT) begin
            k = KIND_LEAD3;
        end
        else if ((b & LEAD4_MASK) == LEAD4_PAT) begin
            k = KIND_LEAD4;
        end
        else if ((b & LEAD4_MASK) == LEAD4_MASK) begin
            k = KIND_INVALID;
        end
        else begin
            k = KIND_CONT;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

/* hdl/u8d_front.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder front stage
// Accepts input beats, classifies each byte and pushes it into the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module u8d_front
    import u8d_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [BYTE_W-1:0] s_tdata,    // [7:0] in_byte
    output logic                   push,
    output u8d_item_t              push_item,
    input  wire logic              q_ready
);

    logic      valid_reg;
    logic      valid_next;
    u8d_item_t item_reg;
    logic      take;

    // Hand the held beat to the queue whenever it has room
    assign push      = valid_reg && q_ready;
    assign push_item = item_reg;
    assign s_tready  = !valid_reg || q_ready;
    assign take      = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture and classify the accepted byte
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.kind <= u8d_classify(s_tdata);
            item_reg.data <= s_tdata;
        end
    end

endmodule

`default_nettype wire

/* hdl/u8d_queue.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder queue
// Short register queue that decouples the front stage from the back stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_byte_stream_decoder_unit_assert.svh"

module u8d_queue
    import u8d_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire u8d_item_t push_item,
    output logic           q_ready,
    output logic           q_valid,
    output u8d_item_t      q_item,
    input  wire logic      pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u8d_item_t        slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign q_ready = (count_reg != CNT_W'(DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];

    // Advance pointers and the fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the pushed beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    `U8D_ASSERT(a_no_overflow, push |-> q_ready, "push into a full queue")
    `U8D_ASSERT(a_no_underflow, pop |-> q_valid, "pop from an empty queue")
    `U8D_ASSERT(a_count_tracks, (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)),
                "fill count did not advance on push")

endmodule

`default_nettype wire

/* hdl/u8d_back.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder back stage
// Tracks the sequence in progress and registers finished code points.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "utf8_byte_stream_decoder_unit_assert.svh"

module u8d_back
    import u8d_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 q_valid,
    input  wire u8d_item_t            q_item,
    output logic                      pop,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [CP_W+LEN_W-1:0]     m_tdata,    // [20:0] code_point, [23:21] seq_length
    output logic                      m_tuser     // [0] status
);

    logic [PEND_W-1:0] pend_reg;
    logic [PEND_W-1:0] pend_next;
    logic [CP_W-1:0]   part_reg;
    logic [CP_W-1:0]   part_next;
    logic [LEN_W-1:0]  total_reg;
    logic [LEN_W-1:0]  total_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [CP_W-1:0]   cp_reg;
    logic [CP_W-1:0]   cp_next;
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic              status_reg;
    logic              status_next;
    logic              emit;
    logic [CP_W-1:0]   shifted;
    logic [PEND_W-1:0] pend_dec;

    // Take a beat when the output slot is free or draining
    assign pop      = q_valid && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {len_reg, cp_reg};
    assign m_tuser  = status_reg;

    assign shifted  = {part_reg[CP_W-7:0], q_item.data[5:0]};
    assign pend_dec = pend_reg - PEND_W'(1);

    // Decode the next byte
    always_comb
    begin
        pend_next   = pend_reg;
        part_next   = part_reg;
        total_next  = total_reg;
        emit        = 1'b0;
        cp_next     = '0;
        len_next    = '0;
        status_next = 1'b0;
        if (pend_reg != '0)
        begin
            // Shift in the continuation payload, unchecked
            pend_next = pend_dec;
            part_next = shifted;
            if (pend_dec == '0)
            begin
                emit       = 1'b1;
                cp_next    = shifted;
                len_next   = total_reg;
                part_next  = '0;
                total_next = '0;
            end
        end
        else
        begin
            case (q_item.kind)
                KIND_ASCII:
                begin
                    emit     = 1'b1;
                    cp_next  = CP_W'(q_item.data[6:0]);
                    len_next = LEN_W'(1);
                end
                KIND_LEAD2:
                begin
                    part_next  = CP_W'(q_item.data[4:0]);
                    pend_next  = PEND_W'(1);
                    total_next = LEN_W'(2);
                end
                KIND_LEAD3:
                begin
                    part_next  = CP_W'(q_item.data[3:0]);
                    pend_next  = PEND_W'(2);
                    total_next = LEN_W'(3);
                end
                KIND_LEAD4:
                begin
                    part_next  = CP_W'(q_item.data[2:0]);
                    pend_next  = PEND_W'(3);
                    total_next = LEN_W'(4);
                end
                default:
                begin
                    // Stray continuation or out of range lead byte
                    emit        = 1'b1;
                    status_next = 1'b1;
                end
            endcase
        end
    end

    always_comb
    begin
        m_valid_next = m_valid_reg && !m_tready;
        if (pop && emit)
        begin
            m_valid_next = 1'b1;
        end
    end

    // Hold sequence state and the output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg    <= '0;
            part_reg    <= '0;
            total_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
            if (pop)
            begin
                pend_reg  <= pend_next;
                part_reg  <= part_next;
                total_reg <= total_next;
            end
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            cp_reg     <= cp_next;
            len_reg    <= len_next;
            status_reg <= status_next;
        end
    end

    `U8D_ASSERT(a_error_clean, (m_valid_reg && status_reg) |-> (cp_reg == '0 && len_reg == '0),
                "error beat carries a code point or length")
    `U8D_ASSERT(a_good_length, (m_valid_reg && !status_reg) |-> (len_reg != '0),
                "decoded beat has zero length")
    `U8D_ASSERT_ALWAYS(a_pend_total, (pend_reg != '0) |-> (total_reg > LEN_W'(pend_reg)),
                "pending count not below sequence length")
    `U8D_ASSERT_ALWAYS(a_idle_clear, (pend_reg == '0) |-> (total_reg == '0 && part_reg == '0),
                "sequence state left over when idle")

endmodule

`default_nettype wire

/* hdl/utf8_byte_stream_decoder_unit.sv */
// ----------------------------------------------------------------------------
// UTF-8 byte stream decoder
// Turns a stream of UTF-8 bytes into code points with their byte lengths.
// ----------------------------------------------------------------------------
// The decoder takes one byte per clock and returns one beat for each completed
// character: the code point and its length in bytes, or an error beat (status
// set, code point and length zero) for a stray continuation byte or a lead
// byte of 0xF8 and above seen with no sequence open. Bytes that only extend a
// sequence produce no beat, and continuation bytes are not checked. The input
// keeps a sustained rate of one byte per cycle while the output is not
// stalled, set by the shift and merge in the back stage; a result is loaded
// into the front register when its last byte is accepted, then into the queue
// slot, then into the output register.
// Output stalls are absorbed by the queue before the input is held off.
`timescale 1ns / 1ps
`default_nettype none

module utf8_byte_stream_decoder_unit
    import u8d_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [BYTE_W-1:0]    s_tdata,    // [7:0] in_byte
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [CP_W+LEN_W-1:0]     m_tdata,    // [20:0] code_point, [23:21] seq_length
    output logic                      m_tuser     // [0] status
);

    logic      push;
    u8d_item_t push_item;
    logic      q_ready;
    logic      q_valid;
    u8d_item_t q_item;
    logic      pop;

    u8d_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready)
    );

    u8d_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .q_ready   (q_ready),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .pop       (pop)
    );

    u8d_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire

/* dv/utf8_decode_checker.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder stream checker
// Watches the byte and code point channels of the decoder, predicts every
// result from the accepted bytes and compares each output beat, in order,
// against the oldest predicted character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_decode_checker
    import u8d_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [BYTE_W-1:0]     s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [CP_W+LEN_W-1:0] m_tdata,
    input  logic                  m_tuser,
    output int                    mismatches,
    output int                    chars_owed
);

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_BAD = 1'b1;
    localparam int   REPORT_MAX = 10;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_length;
        logic             status;
    } decoded_char_t;

    // Decoder state as seen from the byte stream
    logic [PEND_W-1:0] bytes_left;
    logic [CP_W-1:0]   point_acc;
    logic [LEN_W-1:0]  seq_len_acc;
    decoded_char_t     owed_chars[$];

    initial
    begin
        mismatches = 0;
        chars_owed = 0;
    end

    // Advance the decoder state by one byte and queue any finished character
    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        decoded_char_t c;
        c = '0;
        if (bytes_left != 0)
        begin
            // continuation: top bits are not checked
            point_acc  = {point_acc[CP_W-7:0], b[5:0]};
            bytes_left = bytes_left - 1'b1;
            if (bytes_left == 0)
            begin
                c.code_point = point_acc;
                c.seq_length = seq_len_acc;
                c.status     = STATUS_OK;
                owed_chars.push_back(c);
                point_acc   = '0;
                seq_len_acc = '0;
            end
        end
        else if ((b & ASCII_MASK) == 8'h00)
        begin
            c.code_point = CP_W'(b[6:0]);
            c.seq_length = LEN_W'(1);
            c.status     = STATUS_OK;
            owed_chars.push_back(c);
        end
        else if ((b & LEAD2_MASK) == LEAD2_PAT)
        begin
            point_acc   = CP_W'(b[4:0]);
            bytes_left  = PEND_W'(1);
            seq_len_acc = LEN_W'(2);
        end
        else if ((b & LEAD3_MASK) == LEAD3_PAT)
        begin
            point_acc   = CP_W'(b[3:0]);
            bytes_left  = PEND_W'(2);
            seq_len_acc = LEN_W'(3);
        end
        else if ((b & LEAD4_MASK) == LEAD4_PAT)
        begin
            point_acc   = CP_W'(b[2:0]);
            bytes_left  = PEND_W'(3);
            seq_len_acc = LEN_W'(4);
        end
        else
        begin
            // stray continuation or 0xF8 and above: error beat, state kept
            c.status = STATUS_BAD;
            owed_chars.push_back(c);
        end
    endtask

    // Compare one output beat with the oldest owed character
    task automatic check_char(input logic [CP_W+LEN_W-1:0] data, input logic flag);
        decoded_char_t want;
        decoded_char_t got;
        got.code_point = data[CP_W-1:0];
        got.seq_length = data[CP_W+LEN_W-1:CP_W];
        got.status     = flag;
        if (owed_chars.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%0t: unexpected beat cp=%h len=%0d status=%b",
                         $realtime, got.code_point, got.seq_length, got.status);
        end
        else
        begin
            want = owed_chars.pop_front();
            if (got.code_point !== want.code_point || got.seq_length !== want.seq_length ||
                got.status !== want.status)
            begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("%0t: mismatch exp cp=%h len=%0d status=%b, got cp=%h len=%0d status=%b",
                             $realtime, want.code_point, want.seq_length, want.status,
                             got.code_point, got.seq_length, got.status);
            end
        end
    endtask

    // Predict on accepted bytes, check on accepted result beats
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_left  = '0;
            point_acc   = '0;
            seq_len_acc = '0;
            owed_chars.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_byte(s_tdata);
            if (m_tvalid && m_tready)
                check_char(m_tdata, m_tuser);
        end
        chars_owed = owed_chars.size();
    end

endmodule

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// UTF-8 decoder testbench
// Drives directed edge bytes and then random UTF-8 text (mostly well-formed
// characters, some broken sequences and raw noise) into the decoder, with
// random gaps on both channels, a long output stall and a full drain pause.
// The checker beside the block scores every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import u8d_pkg::*;

    localparam int RANDOM_BYTES   = 1150;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES   = 20;
    localparam int CYCLE_LIMIT    = 500000;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [CP_W+LEN_W-1:0] m_tdata;
    logic                  m_tuser;

    int   mismatches;
    int   chars_owed;
    int   cycle_count;
    int   bytes_sent;
    logic tx_idle_on;
    logic rx_hold;

    utf8_byte_stream_decoder_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    utf8_decode_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .mismatches (mismatches),
        .chars_owed (chars_owed)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    // Abort a hung run
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb NOT OK");
            $finish;
        end
    end

    // Gap length: mostly short, a few long
    function automatic int pick_gap();
        int r;
        int g;
        r = $urandom_range(0, 99);
        if (r < 70)
            g = $urandom_range(1, 3);
        else if (r < 95)
            g = $urandom_range(4, 8);
        else
            g = $urandom_range(20, 60);
        return g;
    endfunction

    // Offer one byte from a falling edge and hold it until the beat is taken
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = 0;
        if (tx_idle_on && $urandom_range(0, 99) < 30)
            gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do
            @(posedge clk);
        while (!s_tready);
        bytes_sent++;
        @(negedge clk);
    endtask

    // Encode one character; a broken one gets random continuation bytes
    task automatic send_char(input int len, input logic [CP_W-1:0] cp, input logic broken);
        int k;
        case (len)
            1: send_byte({1'b0, cp[6:0]});
            2: send_byte({3'b110, cp[10:6]});
            3: send_byte({4'b1110, cp[15:12]});
            default: send_byte({5'b11110, cp[20:18]});
        endcase
        for (k = len - 2; k >= 0; k--)
        begin
            if (broken)
                send_byte(8'($urandom_range(0, 255)));
            else
                send_byte({2'b10, cp[6*k +: 6]});
        end
    endtask

    // Output side: random stalls with calm phases, plus one long hold-off
    initial
    begin
        int stall_left;
        int rx_idle_pct;
        int phase_cnt;
        stall_left  = 0;
        rx_idle_pct = 20;
        phase_cnt   = 0;
        m_tready    = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            phase_cnt++;
            if (phase_cnt % 256 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: rx_idle_pct = 0;
                    1: rx_idle_pct = 15;
                    default: rx_idle_pct = 45;
                endcase
            end
            if (rx_hold)
            begin
                m_tready = 1'b0;
                repeat (RX_HOLD_CYCLES) @(negedge clk);
                rx_hold  = 1'b0;
                m_tready = 1'b1;
            end
            else if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready = 1'b1;
                if ($urandom_range(0, 99) < rx_idle_pct)
                    stall_left = pick_gap();
            end
        end
    end

    // Stimulus and verdict
    initial
    begin
        logic [BYTE_W-1:0] edge_bytes[$];
        int                len;
        int                roll;
        logic              held;
        logic              paused;
        logic [CP_W-1:0]   cp;

        s_tvalid   = 1'b0;
        s_tdata    = '0;
        rst_n      = 1'b0;
        tx_idle_on = 1'b0;
        rx_hold    = 1'b0;
        bytes_sent = 0;
        held       = 1'b0;
        paused     = 1'b0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ASCII limits, stray continuations, bytes above 0xF7, shortest and
        // longest sequences, unchecked continuations, surrogate and overlong
        edge_bytes = '{8'h00, 8'h7F, 8'h80, 8'hBF, 8'hF8, 8'hFF,
                       8'hC2, 8'h80, 8'hDF, 8'hBF,
                       8'hE0, 8'h80, 8'h80,
                       8'hF7, 8'hBF, 8'hBF, 8'hBF,
                       8'hC3, 8'h41,
                       8'hE2, 8'hFF, 8'h00,
                       8'hED, 8'hA0, 8'h80,
                       8'hC0, 8'h80};
        foreach (edge_bytes[i])
            send_byte(edge_bytes[i]);

        // Random text
        bytes_sent = 0;
        while (bytes_sent < RANDOM_BYTES)
        begin
            tx_idle_on = ((bytes_sent / 150) % 3 != 2);
            if (!held && bytes_sent >= 300)
            begin
                held    = 1'b1;
                rx_hold = 1'b1;
            end
            if (!paused && bytes_sent >= 600)
            begin
                paused   = 1'b1;
                s_tvalid = 1'b0;
                wait (chars_owed == 0);
                @(negedge clk);
            end
            len  = $urandom_range(1, 4);
            roll = $urandom_range(0, 99);
            case (len)
                1: cp = CP_W'($urandom_range(0, 32'h7F));
                2: cp = CP_W'($urandom_range(0, 32'h7FF));
                3: cp = CP_W'($urandom_range(0, 32'hFFFF));
                default: cp = CP_W'($urandom_range(0, 32'h1FFFFF));
            endcase
            if (roll < 75)
                send_char(len, cp, 1'b0);
            else if (roll < 85)
                send_char(len, cp, 1'b1);
            else
                send_byte(8'($urandom_range(0, 255)));
        end
        s_tvalid = 1'b0;

        // Drain and watch for stray beats
        wait (chars_owed == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && chars_owed == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
